// ===== src/apf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package apf_pkg;

  localparam int RING_BYTES  = 4096;
  localparam int RING_AW     = $clog2(RING_BYTES);
  localparam int PTR_W       = RING_AW + 1;
  localparam int BUF_W       = 13;
  localparam int MAX_RESULTS = 64;
  localparam int REQ_W       = $clog2(MAX_RESULTS) + 1;
  localparam int CNT_W       = $clog2(REQ_W);
  localparam int CFG_AW      = 3;
  localparam int BPF_W       = 4;

  localparam logic [BPF_W-1:0] BPF_RESET = BPF_W'(4);

  // register index, taken from paddr[2]
  localparam logic REG_BPF = 1'b0;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_PULL  = 2'd1,
    OP_EOS   = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_PULL = 3'b100
  } state_e;

endpackage

`default_nettype wire

// ===== src/apf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module apf_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read-before-write on a shared address
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/audio_playback_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Byte FIFO in front of an audio sink, with underrun detection.
// Commands enter on start_i/op_i and friends when busy_o is low. Results
// leave one beat per cycle, marked by result_valid_o; the receiver cannot
// stall, so each beat shows for exactly one cycle. last_o marks the final
// beat of a command, and every beat carries the status after that command.
// Push, set end of stream and clear give one beat in the cycle after the
// command; busy_o stays low, so such a command can be issued every cycle.
// A pull of N bytes (frames times bytes_per_frame, capped at 64) first runs
// a restoring divider for frames rendered, then gives one byte per cycle
// from the sample RAM, busy_o high throughout. A zero-byte pull behaves
// like a single-beat command. bytes_per_frame is to be written over the
// APB port while no command is active; the block does not enforce this.
// Reset clears pointers, counters and flags and sets bytes_per_frame to 4;
// the sample RAM needs no clearing, since only written bytes are read.
module audio_playback_fifo
  import apf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic [1:0]          op_i,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic [3:0]          frame_count_i,
  input  wire logic                eos_value_i,
  output logic                     result_valid_o,
  output logic [7:0]               out_byte_o,
  output logic                     accepted_o,
  output logic                     padded_o,
  output logic                     last_o,
  output logic [BUF_W-1:0]         buffered_bytes_o,
  output logic [31:0]              frames_rendered_o,
  output logic [31:0]              underrun_count_o,
  output logic                     drained_o,
  output logic                     eos_flag_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CFG_AW-1:0]   paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  state_e state_q, state_d;
  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d, cur_q, cur_d;
  logic [31:0]      rendered_q, rendered_d, underrun_q, underrun_d;
  logic             eos_q, eos_d, drained_q, drained_d;
  logic             single_q, single_d, single_acc_q, single_acc_d;
  logic [REQ_W-1:0] wanted_q, wanted_d, got_q, got_d, idx_q, idx_d;
  logic [REQ_W-1:0] num_q, num_d;
  logic [BPF_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [BPF_W-1:0] bpf_q;

  logic             accept, pull_go, cfg_wr;
  logic [PTR_W-1:0] fill;
  logic [7:0]       prod;
  logic [REQ_W-1:0] wanted_c, got_c, quot;
  logic [BPF_W:0]   trial;
  logic             ge, pad, idx_last;
  logic             mem_we;
  logic [7:0]       rd_data;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign fill     = wp_q - rp_q;
  assign prod     = 8'(frame_count_i) * 8'(bpf_q);
  assign wanted_c = (prod > 8'(MAX_RESULTS)) ? REQ_W'(MAX_RESULTS) : prod[REQ_W-1:0];
  assign got_c    = (PTR_W'(wanted_c) < fill) ? wanted_c : fill[REQ_W-1:0];
  assign pull_go  = accept && (op_i == OP_PULL) && (wanted_c != '0);

  // one restoring divider step: got / bytes_per_frame
  assign trial = {rem_q, num_q[REQ_W-1]};
  assign ge    = trial >= {1'b0, bpf_q};
  assign quot  = {num_q[REQ_W-2:0], ge};

  assign pad      = idx_q >= got_q;
  assign idx_last = (idx_q + REQ_W'(1)) == wanted_q;

  always_comb begin
    state_d      = state_q;
    wp_d         = wp_q;
    rp_d         = rp_q;
    cur_d        = cur_q;
    rendered_d   = rendered_q;
    underrun_d   = underrun_q;
    eos_d        = eos_q;
    drained_d    = drained_q;
    single_d     = 1'b0;
    single_acc_d = 1'b0;
    wanted_d     = wanted_q;
    got_d        = got_q;
    idx_d        = idx_q;
    num_d        = num_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    mem_we       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_PUSH: begin
              single_d = 1'b1;
              if (fill < PTR_W'(RING_BYTES)) begin
                mem_we       = 1'b1;
                wp_d         = wp_q + PTR_W'(1);
                drained_d    = 1'b0;
                single_acc_d = 1'b1;
              end
            end
            OP_PULL: begin
              if (wanted_c == '0) begin
                single_d = 1'b1;
              end else begin
                wanted_d = wanted_c;
                got_d    = got_c;
                rp_d     = rp_q + PTR_W'(got_c);
                if (got_c < wanted_c) begin
                  if (eos_q) begin
                    drained_d = 1'b1;
                  end else if (!(got_c == '0 && rendered_q == '0)) begin
                    underrun_d = underrun_q + 32'd1;
                  end
                end
                num_d   = got_c;
                rem_d   = '0;
                cnt_d   = CNT_W'(REQ_W - 1);
                idx_d   = '0;
                state_d = ST_DIV;
              end
            end
            OP_EOS: begin
              single_d = 1'b1;
              eos_d    = eos_value_i;
              if (!eos_value_i) begin
                drained_d = 1'b0;
              end
            end
            OP_CLEAR: begin
              single_d  = 1'b1;
              rp_d      = wp_q;
              drained_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        num_d = quot;
        rem_d = ge ? BPF_W'(trial - {1'b0, bpf_q}) : trial[BPF_W-1:0];
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          rendered_d = rendered_q + 32'(quot);
          state_d    = ST_PULL;
        end
      end
      ST_PULL: begin
        if (!pad) begin
          cur_d = cur_q + PTR_W'(1);
        end
        idx_d = idx_q + REQ_W'(1);
        if (idx_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // read cursor follows the read pointer between pulls
    if (state_q == ST_IDLE && !pull_go) begin
      cur_d = rp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wp_q         <= '0;
      rp_q         <= '0;
      cur_q        <= '0;
      rendered_q   <= '0;
      underrun_q   <= '0;
      eos_q        <= 1'b0;
      drained_q    <= 1'b0;
      single_q     <= 1'b0;
      single_acc_q <= 1'b0;
      wanted_q     <= '0;
      got_q        <= '0;
      idx_q        <= '0;
      cnt_q        <= '0;
    end else begin
      state_q      <= state_d;
      wp_q         <= wp_d;
      rp_q         <= rp_d;
      cur_q        <= cur_d;
      rendered_q   <= rendered_d;
      underrun_q   <= underrun_d;
      eos_q        <= eos_d;
      drained_q    <= drained_d;
      single_q     <= single_d;
      single_acc_q <= single_acc_d;
      wanted_q     <= wanted_d;
      got_q        <= got_d;
      idx_q        <= idx_d;
      cnt_q        <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  // read data holds the byte at the cursor, except just after a write to that address
  apf_ram #(
    .DEPTH (RING_BYTES),
    .WIDTH (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wp_q[RING_AW-1:0]),
    .wdata_i (data_byte_i),
    .raddr_i (cur_d[RING_AW-1:0]),
    .rdata_o (rd_data)
  );

  // config port
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BPF) ? 32'(bpf_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpf_q <= BPF_RESET;
    end else if (cfg_wr && paddr[2] == REG_BPF) begin
      bpf_q <= pwdata[BPF_W-1:0];
    end
  end

  // outputs
  assign busy_o            = (state_q != ST_IDLE);
  assign result_valid_o    = single_q || (state_q == ST_PULL);
  assign out_byte_o        = (state_q == ST_PULL && !pad) ? rd_data : 8'd0;
  assign accepted_o        = single_q && single_acc_q;
  assign padded_o          = (state_q == ST_PULL) && pad;
  assign last_o            = single_q || (state_q == ST_PULL && idx_last);
  assign buffered_bytes_o  = BUF_W'(fill);
  assign frames_rendered_o = rendered_q;
  assign underrun_count_o  = underrun_q;
  assign drained_o         = drained_q;
  assign eos_flag_o        = eos_q;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= PTR_W'(RING_BYTES))
    else $error("fill level above ring size");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(single_q && state_q == ST_PULL))
    else $error("single beat overlaps pull beats");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PULL) |-> (idx_q < wanted_q && got_q <= wanted_q))
    else $error("pull index out of range");

  a_pull_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pull_go |=> (state_q == ST_DIV))
    else $error("pull did not start divider");

  a_pull_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PULL && idx_last) |=> (state_q == ST_IDLE && cur_q == rp_q))
    else $error("read cursor out of step after pull");
`endif

endmodule

`default_nettype wire
